[src/pkaw_pkg.sv]
// Package for the per-key anti-replay window block.
// Request and response types, table geometry and status codes; used by all src files.
package pkaw_pkg;

    localparam int NUM_METERS  = 256;
    localparam int IDX_W       = (NUM_METERS > 1) ? $clog2(NUM_METERS) : 1;
    localparam int NONCE_W     = 64;
    localparam int WIN_W       = 7;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W      = 3;

    localparam logic [WIN_W-1:0] WIN_MAX   = 7'd64;
    localparam logic [WIN_W-1:0] WIN_RESET = 7'd64;

    // Register word index taken from paddr[2].
    localparam logic CFG_IDX_WINDOW = 1'b0;

    localparam logic [1:0] ST_AHEAD    = 2'd0;
    localparam logic [1:0] ST_BACKFILL = 2'd1;
    localparam logic [1:0] ST_REPLAY   = 2'd2;
    localparam logic [1:0] ST_EXPIRED  = 2'd3;

    typedef struct packed {
        logic               mode;
        logic [7:0]         meter_index;
        logic [NONCE_W-1:0] nonce;
    } req_t;

    typedef struct packed {
        logic               accepted;
        logic [1:0]         status;
        logic [NONCE_W-1:0] reported_nonce;
    } rsp_t;

    // Classified request as it waits in the queue.
    typedef struct packed {
        req_t             req;
        logic             in_table;
        logic [WIN_W-1:0] win;
    } qent_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_EVAL,
        B_DONE
    } back_state_t;

endpackage

[src/pkaw_front.sv]
// Front end: accepts requests, classifies them and holds them in a short queue.
// Depends on pkaw_pkg.
module pkaw_front
    import pkaw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  req_t             req,
    input  logic [WIN_W-1:0] win_cfg,
    output logic             head_valid,
    output qent_t            head,
    input  logic             head_pop
);

    qent_t              fifo_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    qent_t              entry;
    logic               push, pop;

    always_comb
    begin
        entry.req      = req;
        entry.in_table = ({24'd0, req.meter_index} < 32'(NUM_METERS));
        // Zero or anything above the bitmap width acts as the full window.
        if (win_cfg == '0 || win_cfg > WIN_MAX)
            entry.win = WIN_MAX;
        else
            entry.win = win_cfg;
    end

    assign req_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push       = req_valid && req_ready;
    assign head_valid = (count_reg != '0);
    assign pop        = head_pop && head_valid;
    assign head       = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= entry;
    end

endmodule

[src/pkaw_back.sv]
// Back end: read-modify-write of the per-meter window table and the response register.
// Depends on pkaw_pkg.
module pkaw_back
    import pkaw_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  head_valid,
    input  qent_t head,
    output logic  head_pop,
    output logic  rsp_valid,
    input  logic  rsp_ready,
    output rsp_t  rsp
);

    back_state_t          state_reg, state_next;
    qent_t                cur_reg;
    logic [NUM_METERS-1:0] valid_bits_reg;
    logic [2*NONCE_W-1:0] table_mem [NUM_METERS];
    logic [2*NONCE_W-1:0] rd_data_reg;
    logic                 hit_reg;
    logic                 gt_reg, gt_next;
    logic [NONCE_W-1:0]   diff_reg, diff_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_t                 rsp_reg, rsp_next;

    logic                 rd_en, load, wr_en;
    logic [IDX_W-1:0]     rd_addr, wr_addr;
    logic [NONCE_W-1:0]   hi, bits, mask, new_bits, new_hi, wr_bits;
    logic [5:0]           sh;

    assign rd_addr = head.req.meter_index[IDX_W-1:0];
    assign wr_addr = cur_reg.req.meter_index[IDX_W-1:0];
    assign hi      = rd_data_reg[2*NONCE_W-1:NONCE_W];
    assign bits    = rd_data_reg[NONCE_W-1:0];
    assign sh      = diff_reg[5:0];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
                if (head_valid)
                    state_next = B_EVAL;
            B_EVAL:
                state_next = B_DONE;
            B_DONE:
                if (!rsp_valid_reg || rsp_ready)
                    state_next = B_IDLE;
            default:
                state_next = B_IDLE;
        endcase
    end

    // Control outputs.
    always_comb
    begin
        head_pop = 1'b0;
        rd_en    = 1'b0;
        load     = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                head_pop = head_valid;
                rd_en    = head_valid;
            end
            B_EVAL:
            begin
            end
            B_DONE:
                load = !rsp_valid_reg || rsp_ready;
            default:
            begin
            end
        endcase
    end

    // Compare and distance from the stored highest nonce.
    always_comb
    begin
        gt_next   = cur_reg.req.nonce > hi;
        diff_next = gt_next ? (cur_reg.req.nonce - hi) : (hi - cur_reg.req.nonce);
    end

    // Window decision and entry update.
    always_comb
    begin
        mask     = (cur_reg.win == WIN_MAX) ? '1 : ((NONCE_W'(1) << cur_reg.win[5:0]) - 1'b1);
        new_bits = bits;
        new_hi   = hi;
        wr_bits  = bits;
        wr_en    = 1'b0;
        rsp_next = rsp_reg;
        if (!hit_reg)
        begin
            rsp_next.accepted       = 1'b1;
            rsp_next.status         = ST_AHEAD;
            rsp_next.reported_nonce = cur_reg.req.mode ? cur_reg.req.nonce : '0;
            new_hi  = cur_reg.req.nonce;
            wr_bits = NONCE_W'(1);
            wr_en   = cur_reg.req.mode && cur_reg.in_table;
        end
        else if (gt_reg)
        begin
            rsp_next.accepted       = 1'b1;
            rsp_next.status         = ST_AHEAD;
            rsp_next.reported_nonce = cur_reg.req.mode ? cur_reg.req.nonce : hi;
            if (diff_reg >= {57'd0, cur_reg.win})
                new_bits = NONCE_W'(1);
            else
                new_bits = ((bits << sh) | NONCE_W'(1)) & mask;
            new_hi  = cur_reg.req.nonce;
            wr_bits = new_bits;
            wr_en   = cur_reg.req.mode;
        end
        else if (diff_reg < {57'd0, cur_reg.win})
        begin
            if (bits[sh])
            begin
                rsp_next.accepted       = 1'b0;
                rsp_next.status         = ST_REPLAY;
                rsp_next.reported_nonce = hi;
            end
            else
            begin
                rsp_next.accepted       = 1'b1;
                rsp_next.status         = ST_BACKFILL;
                rsp_next.reported_nonce = cur_reg.req.mode ? cur_reg.req.nonce : hi;
                wr_bits = bits | (NONCE_W'(1) << sh);
                wr_en   = cur_reg.req.mode;
            end
        end
        else
        begin
            rsp_next.accepted       = 1'b0;
            rsp_next.status         = ST_EXPIRED;
            rsp_next.reported_nonce = hi;
        end
        wr_en = wr_en && load;
    end

    always_comb
    begin
        if (load)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            rsp_valid_reg  <= 1'b0;
            valid_bits_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (wr_en)
                valid_bits_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            cur_reg     <= head;
            rd_data_reg <= table_mem[rd_addr];
            hit_reg     <= valid_bits_reg[rd_addr] && head.in_table;
        end
        if (state_reg == B_EVAL)
        begin
            gt_reg   <= gt_next;
            diff_reg <= diff_next;
        end
        if (wr_en)
            table_mem[wr_addr] <= {new_hi, wr_bits};
        if (load)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[src/per_key_antireplay_window.sv]
// Top level of the per-meter anti-replay window: APB register, front queue and back engine.
// Depends on pkaw_pkg, pkaw_front and pkaw_back.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+---------------------------------
//  req      | in        | req_valid / req_ready  | mode, meter_index, nonce
//  rsp      | out       | rsp_valid / rsp_ready  | accepted, status, reported_nonce
//  apb      | in/out    | psel, penable, pready  | paddr, pwdata, prdata
//
// Each request passes through the back engine in order: table read, compare and distance,
// then window decision with table write and response load; that memory read-modify-write
// keeps one request in the engine at a time, and a stalled response holds it at its end.
// Reset clears all entry valid flags at once; no clearing pass is needed.
// A stalled response holds the engine, while the front queue still takes two more requests.
module per_key_antireplay_window
    import pkaw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  req_t              req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output rsp_t              rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [WIN_W-1:0] window_reg;
    logic             head_valid, head_pop;
    qent_t            head;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == CFG_IDX_WINDOW) ? {25'd0, window_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_reg <= WIN_RESET;
        else if (psel && penable && pwrite && pready && paddr[2] == CFG_IDX_WINDOW)
            window_reg <= pwdata[WIN_W-1:0];
    end

    pkaw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .win_cfg    (window_reg),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop)
    );

    pkaw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp)
    );

endmodule

[src/pkaw_checker.sv]
// Port-level checker for the anti-replay window and its bind to the top level.
// Depends on pkaw_pkg and per_key_antireplay_window.
module pkaw_checker
    import pkaw_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    a_pass_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_AHEAD || rsp.status == ST_BACKFILL) |-> rsp.accepted)
        else $error("ahead or backfill response not accepted");

    a_reject_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_REPLAY || rsp.status == ST_EXPIRED) |-> !rsp.accepted)
        else $error("replay or expired response marked accepted");

    a_no_rsp_after_reset: assert property (@(posedge clk)
        !rst_n |=> !rsp_valid)
        else $error("response valid right after reset");

endmodule

bind per_key_antireplay_window pkaw_checker u_pkaw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

[tb/pkaw_window_checker.sv]
// Scoreboard for the per-meter anti-replay window: follows the register port and both
// request and response channels, predicts each verdict and compares it field by field.
// Depends on pkaw_pkg for the request and response types, table size and status codes.
module pkaw_window_checker
    import pkaw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_ready,
    input  req_t              req,
    input  logic              rsp_valid,
    input  logic              rsp_ready,
    input  rsp_t              rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output int                outstanding,
    output int                errors
);

    logic [WIN_W-1:0]   window_reg;
    logic               entry_live [NUM_METERS];
    logic [NONCE_W-1:0] top_nonce [NUM_METERS];
    logic [NONCE_W-1:0] seen_map [NUM_METERS];
    rsp_t               expected_verdicts [$];

    task automatic report_mismatch(input string what, input logic [NONCE_W-1:0] got,
                                   input logic [NONCE_W-1:0] want);
        $display("checker: %s mismatch, got %0h expected %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    // Works out the verdict for one request and applies a commit to the shadow table.
    function automatic rsp_t judge_nonce(input req_t r);
        rsp_t               v;
        logic [WIN_W-1:0]   win;
        logic [NONCE_W-1:0] hi;
        logic [NONCE_W-1:0] bits;
        logic [NONCE_W-1:0] gap;
        logic [NONCE_W-1:0] keep;
        int unsigned        m;
        logic               tracked;

        m = r.meter_index;
        tracked = (m < NUM_METERS);
        win = (window_reg == '0 || window_reg > WIN_MAX) ? WIN_MAX : window_reg;
        v.accepted = 1'b1;
        v.status = ST_AHEAD;
        v.reported_nonce = r.nonce;

        if (!tracked || !entry_live[m]) begin
            if (!r.mode)
                v.reported_nonce = '0;
            else if (tracked) begin
                entry_live[m] = 1'b1;
                top_nonce[m] = r.nonce;
                seen_map[m] = 64'd1;
            end
            return v;
        end

        hi = top_nonce[m];
        bits = seen_map[m];

        if (r.nonce > hi) begin
            if (!r.mode) begin
                v.reported_nonce = hi;
                return v;
            end
            gap = r.nonce - hi;
            if (gap >= win)
                bits = 64'd1;
            else begin
                keep = (win == WIN_MAX) ? '1 : ((64'd1 << win) - 64'd1);
                bits = ((bits << gap) | 64'd1) & keep;
            end
            top_nonce[m] = r.nonce;
            seen_map[m] = bits;
            return v;
        end

        // At or below the highest nonce: only distances inside the current window are tested.
        gap = hi - r.nonce;
        v.reported_nonce = hi;
        if (gap >= win) begin
            v.accepted = 1'b0;
            v.status = ST_EXPIRED;
        end
        else if (bits[gap[5:0]]) begin
            v.accepted = 1'b0;
            v.status = ST_REPLAY;
        end
        else begin
            v.status = ST_BACKFILL;
            if (r.mode) begin
                seen_map[m] = bits | (64'd1 << gap);
                v.reported_nonce = r.nonce;
            end
        end
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_t want;
        if (!rst_n)
        begin
            window_reg = WIN_RESET;
            for (int i = 0; i < NUM_METERS; i++)
                entry_live[i] = 1'b0;
            expected_verdicts.delete();
            outstanding <= 0;
        end
        else
        begin
            // Responses are checked before this edge's request is queued.
            if (rsp_valid && rsp_ready)
            begin
                if (expected_verdicts.size() == 0)
                    report_mismatch("unexpected response", rsp.reported_nonce, '0);
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (rsp.accepted !== want.accepted)
                        report_mismatch("accepted", 64'(rsp.accepted), 64'(want.accepted));
                    if (rsp.status !== want.status)
                        report_mismatch("status", 64'(rsp.status), 64'(want.status));
                    if (rsp.reported_nonce !== want.reported_nonce)
                        report_mismatch("reported_nonce", rsp.reported_nonce,
                                        want.reported_nonce);
                end
            end
            if (req_valid && req_ready)
                expected_verdicts.insert(expected_verdicts.size(), judge_nonce(req));
            if (psel && penable && pwrite && pready && paddr[ADDR_W-1] == CFG_IDX_WINDOW)
                window_reg = pwdata[WIN_W-1:0];
            outstanding <= expected_verdicts.size();
        end
    end

endmodule

[tb/tb.sv]
// Top of the anti-replay window testbench: clock, reset, register writes, request stimulus
// and response back-pressure. Depends on pkaw_pkg, per_key_antireplay_window and
// pkaw_window_checker, which does all prediction and comparison.
module tb;
    import pkaw_pkg::*;

    localparam logic MODE_CHECK  = 1'b0;
    localparam logic MODE_COMMIT = 1'b1;
    localparam int   STALL_LIMIT = 2000;
    localparam int   RAND_ITEMS  = 1500;
    localparam int   NUM_PHASES  = 9;
    localparam int   HOT_METERS  = 8;
    localparam logic [NONCE_W-1:0] NONCE_TOP = '1;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_ready;
    req_t              req = '0;
    logic              rsp_valid;
    logic              rsp_ready = 1'b0;
    rsp_t              rsp;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    int outstanding;
    int errors;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;

    logic [7:0]         hot [HOT_METERS];
    logic [NONCE_W-1:0] track_hi [NUM_METERS];

    per_key_antireplay_window uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    pkaw_window_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .outstanding (outstanding),
        .errors      (errors)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
        rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_req(input logic mode, input logic [7:0] meter,
                            input logic [NONCE_W-1:0] nonce);
        req_t r;
        r.mode = mode;
        r.meter_index = meter;
        r.nonce = nonce;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    task automatic wait_all_answered();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_window(input int unsigned value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {CFG_IDX_WINDOW, 2'b00};
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Most requests go to a few meters and land near the highest nonce seen there,
    // so backfills, replays and expiries come up often.
    task automatic send_random_req();
        logic               mode;
        logic [7:0]         meter;
        logic [NONCE_W-1:0] base;
        logic [NONCE_W-1:0] nonce;
        int unsigned        pick;
        meter = ($urandom_range(0, 9) < 8) ? hot[$urandom_range(0, HOT_METERS - 1)]
                                           : 8'($urandom_range(0, 255));
        mode = ($urandom_range(0, 9) < 7) ? MODE_COMMIT : MODE_CHECK;
        base = track_hi[meter];
        pick = $urandom_range(0, 99);
        if (pick < 30)
            nonce = base + 64'($urandom_range(1, 8));
        else if (pick < 70)
            nonce = base - 64'($urandom_range(0, 70));
        else if (pick < 80)
            nonce = base + 64'($urandom_range(64, 2000));
        else if (pick < 92)
            nonce = {$urandom, $urandom};
        else
            nonce = $urandom_range(0, 1) ? NONCE_TOP - 64'($urandom_range(0, 3))
                                         : 64'($urandom_range(0, 3));
        if (mode == MODE_COMMIT && nonce > base)
            track_hi[meter] = nonce;
        send_req(mode, meter, nonce);
    endtask

    initial
    begin
        int win_list [NUM_PHASES];
        win_list = '{64, 1, 0, 127, 65, 8, 33, 63, 2};
        hot = '{8'd0, 8'd1, 8'd2, 8'd85, 8'd170, 8'd200, 8'd254, 8'd255};
        for (int i = 0; i < NUM_METERS; i++)
            track_hi[i] = {$urandom, $urandom};
        track_hi[2] = '0;
        track_hi[85] = NONCE_TOP - 64'd20;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset window of 64: empty entries, equal nonces, window edges and jumps.
        send_req(MODE_CHECK,  8'd0, 64'd0);
        send_req(MODE_COMMIT, 8'd0, 64'd100);
        send_req(MODE_COMMIT, 8'd0, 64'd100);
        send_req(MODE_CHECK,  8'd0, 64'd200);
        send_req(MODE_CHECK,  8'd0, 64'd90);
        send_req(MODE_COMMIT, 8'd0, 64'd90);
        send_req(MODE_COMMIT, 8'd0, 64'd90);
        send_req(MODE_COMMIT, 8'd0, 64'd37);
        send_req(MODE_COMMIT, 8'd0, 64'd36);
        send_req(MODE_COMMIT, 8'd0, 64'd110);
        send_req(MODE_COMMIT, 8'd0, 64'd174);
        send_req(MODE_COMMIT, 8'd0, 64'd173);
        send_req(MODE_COMMIT, 8'd255, NONCE_TOP);
        send_req(MODE_COMMIT, 8'd255, 64'd0);
        send_req(MODE_COMMIT, 8'd255, NONCE_TOP - 64'd62);
        send_req(MODE_CHECK,  8'd255, NONCE_TOP);
        send_req(MODE_COMMIT, 8'd1, 64'd0);
        send_req(MODE_COMMIT, 8'd1, 64'd0);
        send_req(MODE_CHECK,  8'd2, NONCE_TOP);
        wait_all_answered();

        // Shrinking the window leaves old bits above it that must not be consulted.
        write_window(4);
        send_req(MODE_COMMIT, 8'd0, 64'd170);
        send_req(MODE_COMMIT, 8'd0, 64'd172);
        send_req(MODE_CHECK,  8'd0, 64'd173);
        wait_all_answered();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_window(win_list[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            for (int i = 0; i < RAND_ITEMS / NUM_PHASES; i++)
            begin
                send_random_req();
                if (p == 2 && i == 60)
                    wait_all_answered();
            end
            wait_all_answered();
        end

        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
